[rtl/core/kvht_pkg.sv]
// package: shared constants and types for the key-value hash table
package kvht_pkg;

    localparam int unsigned BUCKETS_DEF = 64;
    localparam int unsigned WAYS_DEF    = 4;
    localparam logic [63:0] GOLDEN64    = 64'h61C8864680B583EB;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned TOTAL_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request
        logic hash_lo;  // first half of the hash product
        logic hash_hi;  // second half, form bucket address
        logic rd;       // issue row read
        logic wr;       // commit update
        logic clr;      // clear all valid bits
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
    } t_stat;

endpackage

[rtl/core/kvht_if.sv]
// stream interface: valid, ready and payload for one channel
interface kvht_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/key_value_hash_table_top.sv]
// top level: key-value hash table with request and result channels
// A map from 64-bit keys to 64-bit values, one request beat in and one result
// beat out. The controller sequence runs capture, two hash half-products,
// bucket row read, row update and result beat (clear: capture, clear, result
// beat), then returns to the idle state that takes the next beat; a result
// beat that waits on the result side holds the input off until it is taken.
// One request is in flight at a time; a new beat is taken once the previous
// result has been taken. The bucket is the top bits of key times the
// golden-ratio constant; a put to a full bucket is refused with status 2. No
// clearing pass after reset is needed.
module key_value_hash_table_top #(
    parameter int unsigned BUCKETS = kvht_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = kvht_pkg::WAYS_DEF
) (
    input logic  i_clk,
    input logic  i_rst_n,
    kvht_if.sink   in_ch,
    kvht_if.source out_ch
);
    import kvht_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // request beat: {op, key, value_in}
    // result beat: {found, value_out, status, entry_total}
    logic                found;
    logic [VAL_W-1:0]    value_out;
    logic [STAT_W-1:0]   status;
    logic [TOTAL_W-1:0]  entry_total;

    kvht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kvht_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (in_ch.data[KEY_W+VAL_W +: OP_W]),
        .i_key        (in_ch.data[VAL_W +: KEY_W]),
        .i_value_in   (in_ch.data[0 +: VAL_W]),
        .o_found      (found),
        .o_value_out  (value_out),
        .o_status     (status),
        .o_entry_total(entry_total)
    );

    assign out_ch.data = {found, value_out, status, entry_total};
endmodule

[rtl/core/kvht_ctrl.sv]
// controller: sequences hash, row read, update and result beat
module kvht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  kvht_pkg::t_stat i_stat,
    output kvht_pkg::t_cmd  o_cmd
);
    import kvht_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HLO  = 6'b000010,
        S_HHI  = 6'b000100,
        S_RD   = 6'b001000,
        S_WR   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // input is taken once the previous result has left
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HLO;
                end
            end
            S_HLO: begin
                if (i_stat.is_clear) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    o_cmd.hash_lo = 1'b1;
                    n_state       = S_HHI;
                end
            end
            S_HHI: begin
                o_cmd.hash_hi = 1'b1;
                n_state       = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/core/kvht_dp.sv]
// datapath: hash, bucket row memory, valid bits, way match and result
module kvht_dp #(
    parameter int unsigned BUCKETS = kvht_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = kvht_pkg::WAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kvht_pkg::t_cmd                i_cmd,
    output kvht_pkg::t_stat               o_stat,
    input  logic [kvht_pkg::OP_W-1:0]     i_op,
    input  logic [kvht_pkg::KEY_W-1:0]    i_key,
    input  logic [kvht_pkg::VAL_W-1:0]    i_value_in,
    output logic                          o_found,
    output logic [kvht_pkg::VAL_W-1:0]    o_value_out,
    output logic [kvht_pkg::STAT_W-1:0]   o_status,
    output logic [kvht_pkg::TOTAL_W-1:0]  o_entry_total
);
    import kvht_pkg::*;

    localparam int unsigned IB_RAW  = $clog2(BUCKETS + 1) - 1;
    localparam int unsigned IB      = (IB_RAW < 1) ? 1 : IB_RAW;
    localparam int unsigned ROWS    = 1 << IB;
    localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned SLOTS   = ROWS * WAYS;
    localparam int unsigned SLOT_W  = $clog2(SLOTS);

    // request registers
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [63:0]      r_plo;   // key low half times golden low half, then the partial sum
    logic [31:0]      r_phi;   // cross term: key low times golden high, then key high times golden low
    logic [IB-1:0]    r_bkt;

    // memories, one row per bucket
    logic [KEY_W*WAYS-1:0] mem_key [ROWS];
    logic [VAL_W*WAYS-1:0] mem_val [ROWS];
    logic [KEY_W*WAYS-1:0] r_rkey;
    logic [VAL_W*WAYS-1:0] r_rval;
    logic [SLOTS-1:0]      r_valid;
    logic [WAYS-1:0]       r_rvld;
    logic [TOTAL_W-1:0]    r_count;

    logic [63:0]       hash;
    logic [WAYS-1:0]   hit;
    logic [WAYS-1:0]   freev;
    logic [WAY_W-1:0]  hit_w, free_w;
    logic              any_hit, any_free;
    logic [VAL_W-1:0]  hit_val;

    assign o_stat.is_clear = (t_op'(r_op) == OP_CLEAR);

    // low 64 bits of product: high 32 bits get low*low high plus cross term low bits
    assign hash = r_plo + {r_phi, 32'd0};

    always_comb begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_w    = '0;
        free_w   = '0;
        hit_val  = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit[w]   = r_rvld[w] && (r_rkey[w*KEY_W +: KEY_W] == r_key);
            freev[w] = !r_rvld[w];
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit[w]) begin
                any_hit = 1'b1;
                hit_w   = WAY_W'(w);
                hit_val = r_rval[w*VAL_W +: VAL_W];
            end
            if (freev[w]) begin
                any_free = 1'b1;
                free_w   = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_val <= i_value_in;
        end
        if (i_cmd.hash_lo) begin
            r_plo <= 64'(r_key[31:0] * GOLDEN64[31:0]);
            r_phi <= 32'(r_key[31:0] * GOLDEN64[63:32]);
        end
        if (i_cmd.hash_hi) begin
            r_plo <= hash;
            r_phi <= 32'(r_key[63:32] * GOLDEN64[31:0]);
        end
        if (i_cmd.rd) begin
            r_rkey <= mem_key[hash[63 -: IB]];
            r_rval <= mem_val[hash[63 -: IB]];
            r_bkt  <= hash[63 -: IB];
            for (int w = 0; w < WAYS; w++) begin
                r_rvld[w] <= r_valid[SLOT_W'(hash[63 -: IB]) * SLOT_W'(WAYS) + SLOT_W'(w)];
            end
        end
        if (i_cmd.wr && t_op'(r_op) == OP_PUT) begin
            if (any_hit) begin
                mem_val[r_bkt][hit_w*VAL_W +: VAL_W] <= r_val;
            end else if (any_free) begin
                mem_val[r_bkt][free_w*VAL_W +: VAL_W] <= r_val;
                mem_key[r_bkt][free_w*KEY_W +: KEY_W] <= r_key;
            end
        end
    end

    // results and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_count       <= '0;
            o_found       <= 1'b0;
            o_value_out   <= '0;
            o_status      <= ST_OK;
            o_entry_total <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_valid       <= '0;
                r_count       <= '0;
                o_found       <= 1'b0;
                o_value_out   <= '0;
                o_status      <= ST_OK;
                o_entry_total <= '0;
            end
            if (i_cmd.wr) begin
                o_found     <= any_hit;
                o_value_out <= any_hit ? hit_val : '0;
                o_status    <= ST_OK;
                o_entry_total <= r_count;
                if (any_hit) begin
                    if (t_op'(r_op) == OP_REMOVE) begin
                        r_valid[SLOT_W'(r_bkt) * SLOT_W'(WAYS) + SLOT_W'(hit_w)] <= 1'b0;
                        if (r_count != '0) begin
                            r_count       <= r_count - 1'b1;
                            o_entry_total <= r_count - 1'b1;
                        end
                    end
                end else if (t_op'(r_op) == OP_PUT) begin
                    if (any_free) begin
                        r_valid[SLOT_W'(r_bkt) * SLOT_W'(WAYS) + SLOT_W'(free_w)] <= 1'b1;
                        r_count       <= r_count + 1'b1;
                        o_entry_total <= r_count + 1'b1;
                    end else begin
                        o_status <= ST_FULL;
                    end
                end else begin
                    o_status <= ST_NOT_FOUND;
                end
            end
        end
    end
endmodule

[tb/sv/tb.sv]
// testbench for the key-value hash table: scoreboard class, drivers and checks
`timescale 1ns / 100ps

module tb;
    import kvht_pkg::*;

    localparam int unsigned N_BUCKETS = BUCKETS_DEF;
    localparam int unsigned N_WAYS    = WAYS_DEF;
    localparam int unsigned N_SLOTS   = N_BUCKETS * N_WAYS;
    localparam int unsigned IDX_W     = $clog2(N_BUCKETS);
    localparam int unsigned REQ_W     = OP_W + KEY_W + VAL_W;
    localparam int unsigned RSP_W     = 1 + VAL_W + STAT_W + TOTAL_W;
    localparam int unsigned N_RANDOM  = 1520;
    localparam int unsigned CYCLE_CAP = 600000;

    // request and result beats, first field in the top bits
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   value;
        t_status            status;
        logic [TOTAL_W-1:0] total;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    kvht_if #(.W(REQ_W)) req_if ();
    kvht_if #(.W(RSP_W)) rsp_if ();

    key_value_hash_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (req_if),
        .out_ch  (rsp_if)
    );

    // bucket index: top bits of the golden-ratio product
    function automatic int unsigned bucket_index(logic [KEY_W-1:0] key);
        logic [63:0] prod;
        prod = key * GOLDEN64;
        return int'(prod >> (64 - IDX_W));
    endfunction

    // table mirror and queue of predicted result beats
    class kv_scoreboard;
        logic [KEY_W-1:0]   slot_key   [N_SLOTS];
        logic [VAL_W-1:0]   slot_val   [N_SLOTS];
        bit                 slot_used  [N_SLOTS];
        logic [TOTAL_W-1:0] held;
        t_rsp               pending[$];
        int                 errors;
        int                 n_checked;
        int                 n_full;
        int                 n_hit;

        function new();
            held = '0;
            errors = 0;
            n_checked = 0;
            n_full = 0;
            n_hit = 0;
            foreach (slot_used[s]) slot_used[s] = 1'b0;
        endfunction

        task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
            errors++;
            $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
        endtask

        // apply one accepted request to the mirror and queue its result
        function void note_request(t_req r);
            t_rsp        e;
            int unsigned base;
            int          hit;
            e = '{found: 1'b0, value: '0, status: ST_OK, total: '0};
            if (r.op == OP_CLEAR) begin
                foreach (slot_used[s]) slot_used[s] = 1'b0;
                held = '0;
            end else begin
                base = bucket_index(r.key) * N_WAYS;
                hit = -1;
                for (int w = 0; w < N_WAYS; w++)
                    if (hit < 0 && slot_used[base+w] && slot_key[base+w] == r.key)
                        hit = base + w;
                if (hit >= 0) begin
                    n_hit++;
                    e.found = 1'b1;
                    e.value = slot_val[hit];
                    if (r.op == OP_PUT) begin
                        slot_val[hit] = r.value;
                    end else if (r.op == OP_REMOVE) begin
                        slot_used[hit] = 1'b0;
                        if (held != 0) held--;
                    end
                end else if (r.op == OP_PUT) begin
                    e.status = ST_FULL;
                    for (int w = 0; w < N_WAYS; w++)
                        if (e.status == ST_FULL && !slot_used[base+w]) begin
                            slot_used[base+w] = 1'b1;
                            slot_key[base+w]  = r.key;
                            slot_val[base+w]  = r.value;
                            held++;
                            e.status = ST_OK;
                        end
                    if (e.status == ST_FULL) n_full++;
                end else begin
                    e.status = ST_NOT_FOUND;
                end
            end
            e.total = held;
            pending.push_back(e);
        endfunction

        task check_result(t_rsp got);
            t_rsp e;
            n_checked++;
            if (pending.size() == 0) begin
                report("unexpected result beat", got.value, '0);
            end else begin
                e = pending.pop_front();
                if (got.found !== e.found) report("found", 64'(got.found), 64'(e.found));
                if (got.value !== e.value) report("value_out", got.value, e.value);
                if (got.status !== e.status)
                    report("status", 64'(got.status), 64'(e.status));
                if (got.total !== e.total) report("entry_total", 64'(got.total), 64'(e.total));
            end
        endtask
    endclass

    kv_scoreboard sb;
    int unsigned  cycle_count;
    int unsigned  hold_left;     // long receiver hold-off, counted down by the sink
    bit           calm;          // no idling on either side while set
    logic [KEY_W-1:0] key_pool[$];

    // clock and timeout
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("key_value_hash_table_top: mismatch");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // accepted beats are noted and checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) sb.note_request(t_req'(req_if.data));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_result(t_rsp'(rsp_if.data));
    end

    // result side: ready changes at the falling edge, with random stalls
    initial begin : sink_proc
        int unsigned stall;
        rsp_if.ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = 1'b1;
                stall = gap_len();
            end
        end
    end

    // offer one request beat and hold it until taken
    task automatic send_req(t_op op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
        t_req r;
        int unsigned g;
        g = gap_len();
        repeat (g) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        r.op = op;
        r.key = key;
        r.value = value;
        req_if.data  = r;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // random key that lands in the given bucket
    function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned b);
        logic [KEY_W-1:0] k;
        do k = {$urandom, $urandom}; while (bucket_index(k) != b);
        return k;
    endfunction

    function automatic logic [63:0] rand64();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    initial begin : main_proc
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] group[$];
        int unsigned      r;
        t_op              op;

        sb = new();
        cycle_count = 0;
        hold_left = 0;
        calm = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extreme keys and values, hit and miss on put, get and remove
        send_req(OP_GET, '0, '0);
        send_req(OP_REMOVE, '1, '0);
        send_req(OP_PUT, '0, '1);
        send_req(OP_PUT, '1, '0);
        send_req(OP_GET, '0, '0);
        send_req(OP_PUT, '0, 64'h5555_AAAA_5555_AAAA);
        send_req(OP_GET, '1, '1);
        send_req(OP_REMOVE, '0, '0);
        send_req(OP_GET, '0, '0);
        // fill one bucket past its ways so the last put is refused
        for (int i = 0; i <= N_WAYS; i++) group.push_back(key_in_bucket(N_BUCKETS - 1));
        foreach (group[i]) send_req(OP_PUT, group[i], {$urandom, $urandom});
        send_req(OP_REMOVE, group[1], '0);
        send_req(OP_PUT, group[N_WAYS], 64'hAAAA_5555_AAAA_5555);
        send_req(OP_GET, group[N_WAYS], '0);
        send_req(OP_CLEAR, '1, '1);
        send_req(OP_GET, group[0], '0);

        // key pool: crowded buckets to reach full, plus scattered keys
        for (int b = 0; b < 6; b++)
            for (int i = 0; i < N_WAYS + 2; i++) key_pool.push_back(key_in_bucket(b * 7));
        for (int i = 0; i < 40; i++) key_pool.push_back({$urandom, $urandom});

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n % 200) < 40;
            // receiver holds off while the next request is offered
            if (n == 300) hold_left = 400;
            // sender waits for every result before going on
            if (n == 800) wait_drained();
            r = $urandom_range(0, 199);
            if (r < 80) op = OP_PUT;
            else if (r < 140) op = OP_GET;
            else if (r < 198) op = OP_REMOVE;
            else op = OP_CLEAR;
            if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else k = rand64();
            send_req(op, k, rand64());
        end

        wait_drained();
        repeat (30) @(negedge i_clk);
        $display("covered %0d results, %0d key hits, %0d refused puts",
                 sb.n_checked, sb.n_hit, sb.n_full);
        $display("included a long result hold-off and a drained pause");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("key_value_hash_table_top: match");
        end else begin
            $display("key_value_hash_table_top: mismatch");
        end
        $finish;
    end
endmodule
